[rtl/rqfs_pkg.sv]
// rqfs_pkg: shared types and constants for the ready queue scheduler.
// Holds field widths, policy and mode codes, the cell command and running-minimum structs and the FSM state type.
// No dependencies.
package rqfs_pkg;

    localparam int ID_W          = 8;
    localparam int TIME_W        = 16;
    localparam int DEPTH_DEFAULT = 16;
    localparam int ALG_W         = 2;
    localparam int S_DATA_W      = 24;
    localparam int M_DATA_W      = 32;

    // request kinds carried on s_tuser
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_PICK = 1'b1;

    // pick policies
    localparam logic [ALG_W-1:0] POL_FIFO = 2'd0;
    localparam logic [ALG_W-1:0] POL_SJF  = 2'd1;
    localparam logic [ALG_W-1:0] POL_RR   = 2'd2;
    localparam logic [ALG_W-1:0] POL_SRT  = 2'd3;

    // command broadcast to every cell
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rtime;
    } cell_cmd_t;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rtime;
    } best_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_REPORT
    } state_t;

endpackage

[rtl/rqfs_cell.sv]
// rqfs_cell: one queue slot of the ready queue chain.
// Holds one entry, closes up from its right neighbor on removal, and forwards a registered minimum.
// Depends on rqfs_pkg.
module rqfs_cell
    import rqfs_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  cell_idx,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  pop_idx,
    input  logic              prev_valid,
    input  logic              next_valid,
    input  logic [ID_W-1:0]   next_id,
    input  logic [TIME_W-1:0] next_time,
    input  best_t             best_in,
    input  logic [IDX_W-1:0]  best_idx_in,
    output logic              valid,
    output logic [ID_W-1:0]   id,
    output logic [TIME_W-1:0] rtime,
    output best_t             best_out,
    output logic [IDX_W-1:0]  best_idx_out
);

    logic              valid_reg, valid_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [TIME_W-1:0] time_reg, time_next;
    best_t             best_reg, best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;

    // slot update: close up on removal at or left of us, fill if we are the first free slot
    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        if (cmd.pop && (cell_idx >= pop_idx)) begin
            valid_next = next_valid;
            id_next    = next_id;
            time_next  = next_time;
        end else if (cmd.push && !valid_reg && prev_valid) begin
            valid_next = 1'b1;
            id_next    = cmd.id;
            time_next  = cmd.rtime;
        end
    end

    // minimum wave: strict less keeps the earliest arrival on ties
    always_comb begin
        if (valid_reg && (!best_in.found || (time_reg < best_in.rtime))) begin
            best_next     = '{found: 1'b1, id: id_reg, rtime: time_reg};
            best_idx_next = cell_idx;
        end else begin
            best_next     = best_in;
            best_idx_next = best_idx_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            best_reg.found <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            best_reg.found <= best_next.found;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        time_reg       <= time_next;
        best_reg.id    <= best_next.id;
        best_reg.rtime <= best_next.rtime;
        best_idx_reg   <= best_idx_next;
    end

    assign valid        = valid_reg;
    assign id           = id_reg;
    assign rtime        = time_reg;
    assign best_out     = best_reg;
    assign best_idx_out = best_idx_reg;

endmodule

[rtl/ready_queue_fifo_sjf_select.sv]
// ready_queue_fifo_sjf_select: top level of the ready queue scheduler.
// Instantiates a chain of rqfs_cell slots and holds the request sequencer.
// Depends on rqfs_pkg and rqfs_cell.
//
// Usage:
//   Slave stream (s_*): one request per transfer. s_tuser is the mode
//   (0 push, 1 pick); s_tdata carries process_id and the remaining run time.
//   Master stream (m_*): one result per request with the grant, the chosen
//   entry, the reject flag and the empty/full status after the request.
//   cfg_wr_en/cfg_wr_data write the pick policy (0 FIFO, 1 SJF, 2 RR, 3 SRT);
//   write it only while no request is in flight.
//   Timing: a push, or a pick under FIFO or round robin, passes through the
//   apply and report states before m_tvalid rises. A pick under SJF or SRT
//   first scans: the minimum travels through the cell chain one slot per cycle.
//   One request is in flight at a time; s_tready is high only while idle, so
//   no request is taken until the previous result is registered for output.
//   Reset empties the queue (slot contents are left as they are) and selects
//   FIFO. While m_tready is low the finished result is held in the output
//   register and the next request waits at its report step.
module ready_queue_fifo_sjf_select
    import rqfs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [ALG_W-1:0]    cfg_wr_data,    // algorithm
    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,        // [7:0] process_id, [23:8] run_time
    input  logic                s_tuser,        // mode
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata         // [0] granted, [8:1] granted_id,
                                                // [24:9] granted_time, [25] push_rejected,
                                                // [26] queue_empty, [27] queue_full, rest 0
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // cell chain signals
    logic [DEPTH-1:0]  valid_vec;
    logic [ID_W-1:0]   id_arr       [DEPTH];
    logic [TIME_W-1:0] time_arr     [DEPTH];
    best_t             best_arr     [DEPTH];
    logic [IDX_W-1:0]  best_idx_arr [DEPTH];

    cell_cmd_t         cmd;
    logic [IDX_W-1:0]  pop_idx;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ALG_W-1:0]  alg_reg;
    logic              req_mode_reg;
    logic [ID_W-1:0]   req_id_reg;
    logic [TIME_W-1:0] req_time_reg;
    logic              res_granted_reg, res_granted_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [TIME_W-1:0] res_time_reg, res_time_next;
    logic              res_rej_reg, res_rej_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              by_time;
    logic              s_accept;

    assign by_time  = (alg_reg == POL_SJF) || (alg_reg == POL_SRT);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic              prev_v;
        logic              nxt_v;
        logic [ID_W-1:0]   nxt_id;
        logic [TIME_W-1:0] nxt_time;
        best_t             b_in;
        logic [IDX_W-1:0]  b_idx_in;

        if (g == 0) begin : g_head
            assign prev_v   = 1'b1;
            assign b_in     = '0;
            assign b_idx_in = '0;
        end else begin : g_body
            assign prev_v   = valid_vec[g-1];
            assign b_in     = best_arr[g-1];
            assign b_idx_in = best_idx_arr[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign nxt_v    = 1'b0;
            assign nxt_id   = '0;
            assign nxt_time = '0;
        end else begin : g_mid
            assign nxt_v    = valid_vec[g+1];
            assign nxt_id   = id_arr[g+1];
            assign nxt_time = time_arr[g+1];
        end

        rqfs_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cell_idx     (IDX_W'(g)),
            .cmd          (cmd),
            .pop_idx      (pop_idx),
            .prev_valid   (prev_v),
            .next_valid   (nxt_v),
            .next_id      (nxt_id),
            .next_time    (nxt_time),
            .best_in      (b_in),
            .best_idx_in  (b_idx_in),
            .valid        (valid_vec[g]),
            .id           (id_arr[g]),
            .rtime        (time_arr[g]),
            .best_out     (best_arr[g]),
            .best_idx_out (best_idx_arr[g])
        );
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alg_reg <= POL_FIFO;
        end else if (cfg_wr_en) begin
            alg_reg <= cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_mode_reg <= s_tuser;
            req_id_reg   <= s_tdata[ID_W-1:0];
            req_time_reg <= s_tdata[ID_W +: TIME_W];
        end
    end

    // sequencer: next state, cell command and result
    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        res_granted_next = res_granted_reg;
        res_id_next      = res_id_reg;
        res_time_next    = res_time_reg;
        res_rej_next     = res_rej_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        cmd              = '{push: 1'b0, pop: 1'b0, id: req_id_reg, rtime: req_time_reg};
        pop_idx          = by_time ? best_idx_arr[DEPTH-1] : '0;

        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_accept) begin
                    state_next = ((s_tuser == MODE_PICK) && by_time) ? ST_SCAN : ST_APPLY;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DEPTH - 1)) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (req_mode_reg == MODE_PUSH) begin
                    cmd.push         = 1'b1;
                    res_granted_next = 1'b0;
                    res_id_next      = '0;
                    res_time_next    = '0;
                    res_rej_next     = valid_vec[DEPTH-1];
                end else begin
                    cmd.pop          = valid_vec[0];
                    res_granted_next = valid_vec[0];
                    res_rej_next     = 1'b0;
                    if (!valid_vec[0]) begin
                        res_id_next   = '0;
                        res_time_next = '0;
                    end else if (by_time) begin
                        res_id_next   = best_arr[DEPTH-1].id;
                        res_time_next = best_arr[DEPTH-1].rtime;
                    end else begin
                        res_id_next   = id_arr[0];
                        res_time_next = time_arr[0];
                    end
                end
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                // status reflects the queue after the update
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, valid_vec[DEPTH-1], !valid_vec[0],
                                     res_rej_reg, res_time_reg, res_id_reg,
                                     res_granted_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_granted_reg <= res_granted_next;
        res_id_reg      <= res_id_next;
        res_time_reg    <= res_time_next;
        res_rej_reg     <= res_rej_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // occupied slots always form a run starting at the head
    a_valid_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("queue slots are not contiguous");

    // a time-ordered grant never exceeds the head entry's time
    a_min_not_above_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY && req_mode_reg == MODE_PICK && by_time && valid_vec[0])
        |-> (best_arr[DEPTH-1].found && best_arr[DEPTH-1].rtime <= time_arr[0]))
        else $error("minimum search returned a larger time than the head");

    // a result reported into an empty output register carries consistent flags
    a_report_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPORT && !m_tvalid_reg)
        |=> (m_tvalid && !(m_tdata[26] && m_tdata[27]) && !(m_tdata[0] && m_tdata[25])))
        else $error("inconsistent result flags");

endmodule

[bench/tb_top.sv]
// tb_top: self-checking regression for the ready queue scheduler (push, FIFO/RR/SJF/SRT pick).
// A directed table, then random request phases under each policy, with random stalls on both sides.
// Depends on rqfs_pkg and ready_queue_fifo_sjf_select.
`timescale 1ns / 1ps

module tb_top;
    import rqfs_pkg::*;

    // result word as it sits on m_tdata, lowest field last
    typedef struct packed {
        logic [3:0]        pad;
        logic              queue_full;
        logic              queue_empty;
        logic              push_rejected;
        logic [TIME_W-1:0] granted_time;
        logic [ID_W-1:0]   granted_id;
        logic              granted;
    } sched_result_t;

    // one row of the directed table: a policy write or a request
    typedef struct packed {
        logic              is_cfg;
        logic [ALG_W-1:0]  policy;
        logic              mode;
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] rtime;
        logic              typed;
        sched_result_t     want;
    } dir_row_t;

    localparam int QDEPTH     = DEPTH_DEFAULT;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 175;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [ALG_W-1:0]    cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [7:0] process_id, [23:8] run_time
    logic                s_tuser;   // mode
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [0] granted, [8:1] granted_id, [24:9] granted_time,
                                    // [25] push_rejected, [26] queue_empty, [27] queue_full

    // shadow copy of the queue and the policy
    logic [ID_W-1:0]   shadow_id   [QDEPTH];
    logic [TIME_W-1:0] shadow_time [QDEPTH];
    int                shadow_count;
    logic [ALG_W-1:0]  shadow_policy;

    sched_result_t pending_results[$];
    dir_row_t      directed_reqs[$];
    int            error_count;
    int            results_seen;
    bit            send_burst;
    bit            recv_burst;

    logic [ALG_W-1:0] phase_policy [PHASES] =
        '{POL_FIFO, POL_SJF, POL_RR, POL_SRT, POL_SRT, POL_FIFO, POL_SJF, POL_RR};
    int phase_push_pct [PHASES] = '{75, 30, 80, 25, 60, 20, 85, 45};

    // run times for the fill-to-full part of the directed table
    logic [TIME_W-1:0] fill_times [QDEPTH] = '{16'd900, 16'd40, 16'd900, 16'd40,
        16'd7, 16'd300, 16'd7, 16'hFFFF, 16'd1000, 16'd7, 16'd8000, 16'd2,
        16'd2, 16'd555, 16'd6, 16'd2};

    ready_queue_fifo_sjf_select u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic sched_result_t res(logic g, logic [ID_W-1:0] gid,
                                          logic [TIME_W-1:0] gtime, logic rej,
                                          logic emp, logic full);
        sched_result_t r;
        r = '0;
        r.granted       = g;
        r.granted_id    = gid;
        r.granted_time  = gtime;
        r.push_rejected = rej;
        r.queue_empty   = emp;
        r.queue_full    = full;
        return r;
    endfunction

    // advance the shadow queue by one request and return its result
    function automatic sched_result_t schedule_step(logic mode, logic [ID_W-1:0] pid,
                                                    logic [TIME_W-1:0] rtime);
        sched_result_t r;
        int            sel;
        r = '0;
        if (mode == MODE_PUSH) begin
            if (shadow_count >= QDEPTH) begin
                r.push_rejected = 1'b1;
            end else begin
                shadow_id[shadow_count]   = pid;
                shadow_time[shadow_count] = rtime;
                shadow_count++;
            end
        end else if (shadow_count > 0) begin
            sel = 0;
            // shortest remaining time, earliest arrival wins a tie
            if (shadow_policy == POL_SJF || shadow_policy == POL_SRT) begin
                for (int i = 1; i < shadow_count; i++) begin
                    if (shadow_time[i] < shadow_time[sel]) sel = i;
                end
            end
            r.granted      = 1'b1;
            r.granted_id   = shadow_id[sel];
            r.granted_time = shadow_time[sel];
            // close the gap behind the removed entry
            for (int i = sel; i + 1 < shadow_count; i++) begin
                shadow_id[i]   = shadow_id[i + 1];
                shadow_time[i] = shadow_time[i + 1];
            end
            shadow_count--;
        end
        r.queue_empty = (shadow_count == 0);
        r.queue_full  = (shadow_count >= QDEPTH);
        return r;
    endfunction

    task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // result checker: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = m_tdata;
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %0h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("granted", want.granted, got.granted);
                check_field("granted_id", want.granted_id, got.granted_id);
                check_field("granted_time", want.granted_time, got.granted_time);
                check_field("push_rejected", want.push_rejected, got.push_rejected);
                check_field("queue_empty", want.queue_empty, got.queue_empty);
                check_field("queue_full", want.queue_full, got.queue_full);
                check_field("pad", want.pad, got.pad);
            end
        end
    end

    // send one request; starts and ends at a falling edge
    task automatic send_request(logic mode, logic [ID_W-1:0] pid, logic [TIME_W-1:0] rtime,
                                logic typed, sched_result_t want);
        int            gap;
        sched_result_t predicted;
        if ($urandom_range(0, 99) < 4) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rtime, pid};
        s_tuser  <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = schedule_step(mode, pid, rtime);
        pending_results.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // drain, then write the policy register while the block is idle
    task automatic write_policy(logic [ALG_W-1:0] policy);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= policy;
        @(negedge aclk);
        cfg_wr_en     <= 1'b0;
        shadow_policy  = policy;
    endtask

    // result side: random stalls, burst stretches, one long hold
    initial begin
        int stall;
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 99) < 4) recv_burst = ~recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 18);
            if (!held && results_seen >= HOLD_AT) begin
                held  = 1'b1;
                stall = HOLD_LEN;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin
        dir_row_t          row;
        logic              mode;
        logic [TIME_W-1:0] rtime;
        int                kind;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = POL_FIFO;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = MODE_PUSH;
        error_count   = 0;
        results_seen  = 0;
        send_burst    = 1'b0;
        recv_burst    = 1'b0;
        shadow_count  = 0;
        shadow_policy = POL_FIFO;
        for (int i = 0; i < QDEPTH; i++) begin
            shadow_id[i]   = '0;
            shadow_time[i] = '0;
        end

        // directed table: empty pick, extremes, FIFO order, fill to full, tie-breaking picks
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PICK, 8'hA5, 16'h5A5A, 1'b1,
                                  res(1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0)});
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PUSH, 8'hFF, 16'hFFFF, 1'b1,
                                  res(1'b0, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0)});
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PUSH, 8'h00, 16'h0000, 1'b1,
                                  res(1'b0, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0)});
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PICK, 8'h3C, 16'hC3C3, 1'b1,
                                  res(1'b1, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0)});
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PICK, 8'hFF, 16'hFFFF, 1'b1,
                                  res(1'b1, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0)});
        for (int i = 0; i < QDEPTH; i++) begin
            directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PUSH, 8'h10 + 8'(i), fill_times[i],
                                      1'b0, '0});
        end
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PUSH, 8'h77, 16'h0001, 1'b1,
                                  res(1'b0, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1)});
        directed_reqs.push_back('{1'b1, POL_SJF, MODE_PUSH, 8'h00, 16'h0000, 1'b0, '0});
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PICK, 8'h00, 16'h0000, 1'b0, '0});
        directed_reqs.push_back('{1'b1, POL_SRT, MODE_PUSH, 8'h00, 16'h0000, 1'b0, '0});
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PICK, 8'h00, 16'h0000, 1'b0, '0});
        directed_reqs.push_back('{1'b1, POL_RR, MODE_PUSH, 8'h00, 16'h0000, 1'b0, '0});
        directed_reqs.push_back('{1'b0, POL_FIFO, MODE_PICK, 8'h00, 16'h0000, 1'b0, '0});

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_reqs[i]) begin
            row = directed_reqs[i];
            if (row.is_cfg) write_policy(row.policy);
            else send_request(row.mode, row.pid, row.rtime, row.typed, row.want);
        end

        // random phases: each policy, with push bias that fills or drains the queue
        for (int p = 0; p < PHASES; p++) begin
            write_policy(phase_policy[p]);
            for (int n = 0; n < PHASE_REQS; n++) begin
                mode = ($urandom_range(0, 99) < phase_push_pct[p]) ? MODE_PUSH : MODE_PICK;
                kind = $urandom_range(0, 9);
                // narrow range makes ties common; extremes now and then
                if (kind < 3)       rtime = TIME_W'($urandom_range(0, 3));
                else if (kind == 3) rtime = 16'h0000;
                else if (kind == 4) rtime = 16'hFFFF;
                else                rtime = TIME_W'($urandom());
                send_request(mode, ID_W'($urandom()), rtime, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (2 * QDEPTH + 10) @(negedge aclk);
        if (error_count == 0) begin
            $display("ready_queue_fifo_sjf_select regression: pass");
        end else begin
            $display("ready_queue_fifo_sjf_select regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("ready_queue_fifo_sjf_select regression: fail");
        $finish;
    end

endmodule
